FILE: rtl/core/kta_pkg.sv
// ----------------------------------------------------------------------------
// Keyed threshold alert table package
// Sizes, opcodes and the slot store's write and read bundles.
// ----------------------------------------------------------------------------
package kta_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LIMIT_W  = 5;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned PEND_W   = 6;

  localparam logic [3:0] OP_ADD       = 4'd0;
  localparam logic [3:0] OP_REMOVE    = 4'd1;
  localparam logic [3:0] OP_CLEAR     = 4'd2;
  localparam logic [3:0] OP_SET_BUY   = 4'd3;
  localparam logic [3:0] OP_SET_SELL  = 4'd4;
  localparam logic [3:0] OP_CLR_BUY   = 4'd5;
  localparam logic [3:0] OP_CLR_SELL  = 4'd6;
  localparam logic [3:0] OP_PRICE     = 4'd7;
  localparam logic [3:0] OP_ACK       = 4'd8;
  localparam logic [3:0] OP_ACK_ALL   = 4'd9;
  localparam logic [3:0] OP_LOOKUP    = 4'd10;

  localparam int unsigned FL_BUY_ARMED  = 0;
  localparam int unsigned FL_BUY_FIRED  = 1;
  localparam int unsigned FL_SELL_ARMED = 2;
  localparam int unsigned FL_SELL_FIRED = 3;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  idx;
    logic              valid;
    logic [31:0]       key;
    logic [31:0]       price;
    logic [31:0]       buy_level;
    logic [31:0]       sell_level;
    logic [3:0]        flags;
    logic              clear_all;
    logic              ack_all;
  } kta_wr_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] price;
    logic [31:0] buy_level;
    logic [31:0] sell_level;
    logic [3:0]  flags;
  } kta_rd_t;

endpackage

FILE: rtl/core/kta_slots.sv
// ----------------------------------------------------------------------------
// Keyed threshold alert table slot store
// Per-slot key, price, levels and flags with one indexed read and write port,
// plus whole-table clear and acknowledge.
// ----------------------------------------------------------------------------
module kta_slots (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [kta_pkg::IDX_W-1:0] rd_idx_i,
  input  kta_pkg::kta_wr_t wr_i,
  output kta_pkg::kta_rd_t rd_o
);
  import kta_pkg::*;

  logic [CAPACITY-1:0] valid_q;
  logic [31:0]         key_q   [CAPACITY];
  logic [31:0]         price_q [CAPACITY];
  logic [31:0]         buy_q   [CAPACITY];
  logic [31:0]         sell_q  [CAPACITY];
  logic [3:0]          flags_q [CAPACITY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.clear_all) begin
      valid_q <= '0;
    end else if (wr_i.wr_en) begin
      valid_q[wr_i.idx] <= wr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      key_q[wr_i.idx]   <= wr_i.key;
      price_q[wr_i.idx] <= wr_i.price;
      buy_q[wr_i.idx]   <= wr_i.buy_level;
      sell_q[wr_i.idx]  <= wr_i.sell_level;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (wr_i.ack_all) begin
        flags_q[i][FL_BUY_FIRED]  <= 1'b0;
        flags_q[i][FL_SELL_FIRED] <= 1'b0;
      end else if (wr_i.wr_en && (wr_i.idx == IDX_W'(i))) begin
        flags_q[i] <= wr_i.flags;
      end
    end
  end

  always_comb begin
    rd_o.valid      = valid_q[rd_idx_i];
    rd_o.key        = key_q[rd_idx_i];
    rd_o.price      = price_q[rd_idx_i];
    rd_o.buy_level  = buy_q[rd_idx_i];
    rd_o.sell_level = sell_q[rd_idx_i];
    rd_o.flags      = flags_q[rd_idx_i];
  end

endmodule

FILE: rtl/core/keyed_threshold_alert_table.sv
// ----------------------------------------------------------------------------
// Keyed threshold alert table
// Keyed entries with price, buy and sell levels and one-shot alert latches.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                 | Payload
//  request  | in_valid_i / in_stall_o   | opcode_i, entry_key_i, value_i
//  result   | out_valid_o / out_stall_i | ok_o, price_o, buy/sell_alert_o,
//           |                           | entry_count_o, pending_alerts_o,
//           |                           | total_alerts_o
//  config   | psel/penable/pwrite       | paddr, pwdata, prdata, pready
//
// After a request is accepted, the scan makes one key compare per slot, then
// the addressed slot is updated and the result registered. The request side
// stalls from acceptance until the result is registered, so no new request
// is taken before then, and a waiting result holds the update cycle.
// Reset empties the table and zeroes the alert total; the limit resets to 16.
// ----------------------------------------------------------------------------
module keyed_threshold_alert_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  opcode_i,
  input  logic [31:0] entry_key_i,
  input  logic signed [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic signed [31:0] price_o,
  output logic        buy_alert_o,
  output logic        sell_alert_o,
  output logic [4:0]  entry_count_o,
  output logic [5:0]  pending_alerts_o,
  output logic [31:0] total_alerts_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kta_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               hit_q, hit_d, free_q, free_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [3:0]         op_q;
  logic [31:0]        key_q, val_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [COUNT_W-1:0] held_q, held_d;
  logic [PEND_W-1:0]  pend_q, pend_d;
  logic [31:0]        total_q, total_d;

  logic               out_valid_q;
  logic               res_ok_q, res_buy_q, res_sell_q;
  logic [31:0]        res_price_q;

  logic               res_ok, res_present;
  logic [31:0]        res_price;
  logic [3:0]         res_flags;

  kta_wr_t            wr;
  kta_rd_t            rd;

  logic               in_acc, exec_go, key_match, val_pos;
  logic [LIMIT_W-1:0] limit_eff;
  logic [1:0]         fired_old, fired_new, bumps;
  logic [32:0]        total_sum;
  logic [3:0]         f;

  kta_slots u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (idx_q),
    .wr_i     (wr),
    .rd_o     (rd)
  );

  assign pready = 1'b1;
  assign prdata = {{(32 - LIMIT_W){1'b0}}, limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_W'(16);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign exec_go    = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign key_match  = rd.valid && (rd.key == key_q);
  assign val_pos    = !val_q[31] && (val_q != 32'd0);
  assign limit_eff  = (32'(limit_q) < CAPACITY) ? limit_q : LIMIT_W'(CAPACITY);
  assign fired_old  = {rd.flags[FL_SELL_FIRED], rd.flags[FL_BUY_FIRED]};

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
          idx_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      ST_SCAN: begin
        if (key_match && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = idx_q;
        end
        if (!rd.valid && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = idx_q;
        end
        if (idx_q == IDX_W'(CAPACITY - 1)) begin
          state_d = ST_EXEC;
          idx_d   = hit_d ? hit_idx_d : free_idx_d;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    wr            = '0;
    wr.idx        = idx_q;
    wr.valid      = rd.valid;
    wr.key        = rd.key;
    wr.price      = rd.price;
    wr.buy_level  = rd.buy_level;
    wr.sell_level = rd.sell_level;
    wr.flags      = rd.flags;
    held_d        = held_q;
    pend_d        = pend_q;
    total_d       = total_q;
    res_ok        = 1'b0;
    res_present   = hit_q;
    res_price     = rd.price;
    res_flags     = rd.flags;
    f             = rd.flags;
    bumps         = 2'b00;
    fired_new     = 2'b00;
    total_sum     = {1'b0, total_q};
    case (op_q)
      OP_ADD: begin
        if (key_q != 32'd0 && !hit_q && (held_q < limit_eff)) begin
          wr.valid      = 1'b1;
          wr.key        = key_q;
          wr.price      = val_q;
          wr.buy_level  = '0;
          wr.sell_level = '0;
          wr.flags      = '0;
          wr.wr_en      = 1'b1;
          held_d        = held_q + 1'b1;
          res_ok        = 1'b1;
          res_present   = 1'b1;
          res_price     = val_q;
          res_flags     = '0;
        end
      end
      OP_REMOVE: begin
        if (hit_q) begin
          wr.valid    = 1'b0;
          wr.wr_en    = 1'b1;
          held_d      = held_q - 1'b1;
          pend_d      = pend_q - PEND_W'(fired_old[0]) - PEND_W'(fired_old[1]);
          res_ok      = 1'b1;
          res_present = 1'b0;
        end
      end
      OP_CLEAR: begin
        wr.clear_all = 1'b1;
        held_d       = '0;
        pend_d       = '0;
        res_ok       = 1'b1;
        res_present  = 1'b0;
      end
      OP_SET_BUY, OP_CLR_BUY: begin
        if (hit_q && (val_pos || op_q == OP_CLR_BUY)) begin
          f[FL_BUY_ARMED] = (op_q == OP_SET_BUY);
          f[FL_BUY_FIRED] = 1'b0;
          wr.buy_level    = (op_q == OP_SET_BUY) ? val_q : 32'd0;
          wr.flags        = f;
          wr.wr_en        = 1'b1;
          pend_d          = pend_q - PEND_W'(fired_old[0]);
          res_ok          = 1'b1;
          res_flags       = f;
        end
      end
      OP_SET_SELL, OP_CLR_SELL: begin
        if (hit_q && (val_pos || op_q == OP_CLR_SELL)) begin
          f[FL_SELL_ARMED] = (op_q == OP_SET_SELL);
          f[FL_SELL_FIRED] = 1'b0;
          wr.sell_level    = (op_q == OP_SET_SELL) ? val_q : 32'd0;
          wr.flags         = f;
          wr.wr_en         = 1'b1;
          pend_d           = pend_q - PEND_W'(fired_old[1]);
          res_ok           = 1'b1;
          res_flags        = f;
        end
      end
      OP_PRICE: begin
        if (hit_q) begin
          fired_new[0] = rd.flags[FL_BUY_ARMED] && !rd.flags[FL_BUY_FIRED] &&
                         ($signed(val_q) <= $signed(rd.buy_level));
          fired_new[1] = rd.flags[FL_SELL_ARMED] && !rd.flags[FL_SELL_FIRED] &&
                         ($signed(val_q) >= $signed(rd.sell_level));
          f[FL_BUY_FIRED]  = rd.flags[FL_BUY_FIRED] | fired_new[0];
          f[FL_SELL_FIRED] = rd.flags[FL_SELL_FIRED] | fired_new[1];
          bumps        = 2'(fired_new[0]) + 2'(fired_new[1]);
          total_sum    = {1'b0, total_q} + 33'(bumps);
          total_d      = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
          pend_d       = pend_q + PEND_W'(bumps);
          wr.price     = val_q;
          wr.flags     = f;
          wr.wr_en     = 1'b1;
          res_ok       = 1'b1;
          res_price    = val_q;
          res_flags    = f;
        end
      end
      OP_ACK: begin
        if (hit_q) begin
          f[FL_BUY_FIRED]  = 1'b0;
          f[FL_SELL_FIRED] = 1'b0;
          wr.flags         = f;
          wr.wr_en         = 1'b1;
          pend_d           = pend_q - PEND_W'(fired_old[0]) - PEND_W'(fired_old[1]);
          res_ok           = 1'b1;
          res_flags        = f;
        end
      end
      OP_ACK_ALL: begin
        wr.ack_all                = 1'b1;
        pend_d                    = '0;
        res_ok                    = 1'b1;
        res_flags[FL_BUY_FIRED]   = 1'b0;
        res_flags[FL_SELL_FIRED]  = 1'b0;
      end
      OP_LOOKUP: begin
        res_ok = hit_q;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
    if (!exec_go) begin
      wr.wr_en     = 1'b0;
      wr.clear_all = 1'b0;
      wr.ack_all   = 1'b0;
      held_d       = held_q;
      pend_d       = pend_q;
      total_d      = total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      held_q      <= '0;
      pend_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
      held_q  <= held_d;
      pend_q  <= pend_d;
      total_q <= total_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (in_acc) begin
      op_q  <= opcode_i;
      key_q <= entry_key_i;
      val_q <= value_i;
    end
    if (exec_go) begin
      res_ok_q    <= res_ok;
      res_price_q <= res_present ? res_price : 32'd0;
      res_buy_q   <= res_present && res_flags[FL_BUY_FIRED];
      res_sell_q  <= res_present && res_flags[FL_SELL_FIRED];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = res_ok_q;
  assign price_o          = res_price_q;
  assign buy_alert_o      = res_buy_q;
  assign sell_alert_o     = res_sell_q;
  assign entry_count_o    = held_q;
  assign pending_alerts_o = pend_q;
  assign total_alerts_o   = total_q;

  a_accept_starts_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_SCAN)
    else $error("accepted request did not start a scan");

  a_held_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(held_q) <= CAPACITY)
    else $error("entry count exceeds capacity");

  a_pending_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pend_q} <= {1'b0, held_q, 1'b0})
    else $error("pending alerts exceed two per entry");

  a_result_from_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_EXEC)
    else $error("result raised outside the update cycle");

endmodule
